// ----- design/rmq_pkg.sv -----
// shared types and constants for the rotation matrix to quaternion block
`default_nettype none
package rmq_pkg;

   // matrix element and quaternion component width
   localparam int ELEM_W      = 16;
   // signed width of a raw quaternion component before normalizing
   localparam int RAW_W       = 32;
   // magnitude width; normalizing brings the largest into [2^30, 2^31)
   localparam int MAG_W       = 31;
   localparam int NORM_STEPS  = $clog2(MAG_W);
   localparam int SQ_W        = 2 * MAG_W;
   localparam int PAIR_W      = SQ_W + 1;
   localparam int SUM_W       = SQ_W + 2;
   localparam int ROOT_W      = SUM_W / 2;
   localparam int REM_W       = ROOT_W + 3;
   localparam int QUEUE_DEPTH = 2;

   typedef logic signed [ELEM_W-1:0] elem_type;

   // one classified item between front and back
   typedef struct packed {
      logic [3:0][MAG_W-1:0] mag;
      logic [MAG_W-1:0]      mx;
      logic [3:0]            neg;
      logic                  degen;
   } entry_type;

   // what travels beside the square root
   typedef struct packed {
      logic [3:0][MAG_W-1:0] mag;
      logic [3:0]            neg;
      logic                  degen;
   } side_type;

endpackage
`default_nettype wire

// ----- design/rotation_matrix_to_quaternion.sv -----
// top level: rotation matrix to unit quaternion converter
//
// Converts a 3x3 rotation matrix in signed fixed point (FRAC_BITS fraction
// bits) to a normalized quaternion w, x, y, z by Shepperd's method. One item
// is taken per clock cycle when the result side does not stall. The back
// pipeline holds the normalize, square and add stages, the 32-stage square
// root and the FRAC_BITS + 1 stage divider. The front registers and classifies
// each item and feeds a two-entry queue; the back pipeline freezes only while
// a finished result waits, so the input keeps accepting until the queue fills.
// A non-positive radicand or an all-zero vector gives the identity quaternion
// with degenerate set.
`default_nettype none
module rotation_matrix_to_quaternion #(
   parameter int FRAC_BITS = 14
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rmq_pkg::elem_type req_m00,
   input  rmq_pkg::elem_type req_m01,
   input  rmq_pkg::elem_type req_m02,
   input  rmq_pkg::elem_type req_m10,
   input  rmq_pkg::elem_type req_m11,
   input  rmq_pkg::elem_type req_m12,
   input  rmq_pkg::elem_type req_m20,
   input  rmq_pkg::elem_type req_m21,
   input  rmq_pkg::elem_type req_m22,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rmq_pkg::elem_type rsp_quat_w,
   output rmq_pkg::elem_type rsp_quat_x,
   output rmq_pkg::elem_type rsp_quat_y,
   output rmq_pkg::elem_type rsp_quat_z,
   output logic              rsp_degenerate
);
   import rmq_pkg::*;

   logic      ent_valid, ent_full;
   entry_type ent_data;
   logic      q_valid, q_pop;
   entry_type q_data;

   // accept and classify
   rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_m00   (req_m00),
      .req_m01   (req_m01),
      .req_m02   (req_m02),
      .req_m10   (req_m10),
      .req_m11   (req_m11),
      .req_m12   (req_m12),
      .req_m20   (req_m20),
      .req_m21   (req_m21),
      .req_m22   (req_m22),
      .ent_valid (ent_valid),
      .ent_full  (ent_full),
      .ent_data  (ent_data)
   );

   // decoupling queue
   rmq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (ent_valid),
      .push_data  (ent_data),
      .full       (ent_full),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_data   (q_data)
   );

   // arithmetic pipeline
   rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (q_valid),
      .in_data        (q_data),
      .in_pop         (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_quat_w     (rsp_quat_w),
      .rsp_quat_x     (rsp_quat_x),
      .rsp_quat_y     (rsp_quat_y),
      .rsp_quat_z     (rsp_quat_z),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule
`default_nettype wire

// ----- design/rmq_front.sv -----
// input register and branch classification
`default_nettype none
module rmq_front #(
   parameter int FRAC_BITS = 14
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  rmq_pkg::elem_type   req_m00,
   input  rmq_pkg::elem_type   req_m01,
   input  rmq_pkg::elem_type   req_m02,
   input  rmq_pkg::elem_type   req_m10,
   input  rmq_pkg::elem_type   req_m11,
   input  rmq_pkg::elem_type   req_m12,
   input  rmq_pkg::elem_type   req_m20,
   input  rmq_pkg::elem_type   req_m21,
   input  rmq_pkg::elem_type   req_m22,
   output logic                ent_valid,
   input  logic                ent_full,
   output rmq_pkg::entry_type  ent_data
);
   import rmq_pkg::*;

   localparam logic signed [RAW_W-1:0] ONE = RAW_W'(64'd1 << FRAC_BITS);

   logic     valid_ff, valid_in;
   elem_type m_ff [9];
   elem_type m_in [9];

   logic signed [RAW_W-1:0] e [9];
   logic signed [RAW_W-1:0] t, sx, sy, sz, p01, p02, p12, u0, u1, u2;
   logic signed [RAW_W-1:0] raw [4];
   logic signed [RAW_W-1:0] raw_abs [4];
   logic                    rad_bad;
   logic [MAG_W-1:0]        mx01, mx23;

   // hold the item while the queue is full
   assign req_stall = valid_ff && ent_full;
   assign ent_valid = valid_ff;

   always_comb begin
      valid_in = req_stall ? valid_ff : req_valid;
      if (req_stall) begin
         m_in = m_ff;
      end else begin
         m_in = '{req_m00, req_m01, req_m02, req_m10, req_m11,
                  req_m12, req_m20, req_m21, req_m22};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in;
   end

   // trace test, major diagonal pick and raw vector
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         e[i] = RAW_W'(m_ff[i]);
      end
      t   = ONE + e[0] + e[4] + e[8];
      sx  = e[7] - e[5];
      sy  = e[2] - e[6];
      sz  = e[3] - e[1];
      p01 = e[1] + e[3];
      p02 = e[2] + e[6];
      p12 = e[5] + e[7];
      u0  = ONE + e[0] - e[4] - e[8];
      u1  = ONE - e[0] + e[4] - e[8];
      u2  = ONE - e[0] - e[4] + e[8];
      priority if (t > 0) begin
         raw     = '{t, sx, sy, sz};
         rad_bad = 1'b0;
      end else if (e[0] >= e[4] && e[0] >= e[8]) begin
         raw     = '{sx, u0, p01, p02};
         rad_bad = (u0 <= 0);
      end else if (!(e[0] >= e[4]) && e[4] >= e[8]) begin
         raw     = '{sy, p01, u1, p12};
         rad_bad = (u1 <= 0);
      end else begin
         raw     = '{sz, p02, p12, u2};
         rad_bad = (u2 <= 0);
      end
   end

   // sign and magnitude, largest magnitude
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         ent_data.neg[i] = raw[i][RAW_W-1];
         raw_abs[i]      = raw[i][RAW_W-1] ? -raw[i] : raw[i];
         ent_data.mag[i] = MAG_W'(raw_abs[i]);
      end
      mx01 = (ent_data.mag[0] > ent_data.mag[1]) ? ent_data.mag[0] : ent_data.mag[1];
      mx23 = (ent_data.mag[2] > ent_data.mag[3]) ? ent_data.mag[2] : ent_data.mag[3];
      ent_data.mx    = (mx01 > mx23) ? mx01 : mx23;
      ent_data.degen = rad_bad || (ent_data.mx == '0);
   end

endmodule
`default_nettype wire

// ----- design/rmq_queue.sv -----
// short queue between front and back
`default_nettype none
module rmq_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  rmq_pkg::entry_type push_data,
   output logic               full,
   output logic               pop_valid,
   input  logic               pop,
   output rmq_pkg::entry_type pop_data
);
   import rmq_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ff];
   assign push      = push_valid && !full;

   // pointer and count update
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // item storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue popped while empty");
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (full && !pop) |=> full)
      else $error("queue lost an item while full");
   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("queue count missed a push");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

// ----- design/rmq_isqrt.sv -----
// pipelined integer square root, one result bit per stage
`default_nettype none
module rmq_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  logic [rmq_pkg::SUM_W-1:0]    in_value,
   input  rmq_pkg::side_type            in_side,
   output logic                         out_valid,
   output logic [rmq_pkg::ROOT_W-1:0]   out_root,
   output rmq_pkg::side_type            out_side
);
   import rmq_pkg::*;

   logic              valid_ff [ROOT_W];
   logic [REM_W-1:0]  rem_ff   [ROOT_W];
   logic [REM_W-1:0]  rem_in   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_in  [ROOT_W];
   logic [SUM_W-1:0]  val_ff   [ROOT_W];
   logic [SUM_W-1:0]  val_in   [ROOT_W];
   side_type          side_ff  [ROOT_W];

   logic              src_valid [ROOT_W];
   logic [REM_W-1:0]  src_rem   [ROOT_W];
   logic [ROOT_W-1:0] src_root  [ROOT_W];
   logic [SUM_W-1:0]  src_val   [ROOT_W];
   side_type          src_side  [ROOT_W];

   for (genvar s = 0; s < ROOT_W; s++) begin : g_step
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      logic             take;

      if (s == 0) begin : g_first
         assign src_valid[s] = in_valid;
         assign src_rem[s]   = '0;
         assign src_root[s]  = '0;
         assign src_val[s]   = in_value;
         assign src_side[s]  = in_side;
      end else begin : g_next
         assign src_valid[s] = valid_ff[s-1];
         assign src_rem[s]   = rem_ff[s-1];
         assign src_root[s]  = root_ff[s-1];
         assign src_val[s]   = val_ff[s-1];
         assign src_side[s]  = side_ff[s-1];
      end

      // bring down two radicand bits, try 4r+1
      always_comb begin
         rem_sh     = {src_rem[s][REM_W-3:0], src_val[s][SUM_W-1 -: 2]};
         trial      = REM_W'({src_root[s], 2'b01});
         take       = (rem_sh >= trial);
         rem_in[s]  = take ? rem_sh - trial : rem_sh;
         root_in[s] = {src_root[s][ROOT_W-2:0], take};
         val_in[s]  = {src_val[s][SUM_W-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= src_valid[s];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
            val_ff[s]  <= val_in[s];
            side_ff[s] <= src_side[s];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule
`default_nettype wire

// ----- design/rmq_back.sv -----
// normalize, square, root, divide and output register
`default_nettype none
module rmq_back #(
   parameter int FRAC_BITS = 14
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  rmq_pkg::entry_type  in_data,
   output logic                in_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rmq_pkg::elem_type   rsp_quat_w,
   output rmq_pkg::elem_type   rsp_quat_x,
   output rmq_pkg::elem_type   rsp_quat_y,
   output rmq_pkg::elem_type   rsp_quat_z,
   output logic                rsp_degenerate
);
   import rmq_pkg::*;

   localparam int Q_W   = FRAC_BITS + 1;
   localparam int DIV_W = MAG_W + FRAC_BITS + 1;
   localparam logic [ELEM_W-1:0] ONE_SAT =
      (FRAC_BITS >= ELEM_W - 1) ? 16'h7fff : ELEM_W'(32'd1 << FRAC_BITS);

   logic advance;

   // normalize stages
   entry_type nsrc       [NORM_STEPS];
   logic      nsrc_valid [NORM_STEPS];
   entry_type norm_ff    [NORM_STEPS];
   entry_type norm_in    [NORM_STEPS];
   logic      nvalid_ff  [NORM_STEPS];

   // squares and sums
   logic [SQ_W-1:0]   sq_ff   [4];
   logic [SQ_W-1:0]   sq_in   [4];
   side_type          sq_side_ff, sq_side_in;
   logic              sq_valid_ff;
   logic [PAIR_W-1:0] pair_ff [2];
   logic [PAIR_W-1:0] pair_in [2];
   side_type          pair_side_ff;
   logic              pair_valid_ff;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   side_type          sum_side_ff;
   logic              sum_valid_ff;

   // root
   logic              root_valid;
   logic [ROOT_W-1:0] root;
   side_type          root_side;

   // division lanes
   logic              dvalid_ff [Q_W+1];
   logic [DIV_W-1:0]  drem_ff   [Q_W+1][4];
   logic [DIV_W-1:0]  drem_in   [Q_W+1][4];
   logic [Q_W-1:0]    dq_ff     [Q_W+1][4];
   logic [Q_W-1:0]    dq_in     [Q_W+1][4];
   logic [ROOT_W-1:0] dn_ff     [Q_W+1];
   logic [3:0]        dneg_ff   [Q_W+1];
   logic              ddeg_ff   [Q_W+1];

   // output register
   logic              rsp_valid_ff;
   elem_type          q_ff [4];
   elem_type          q_in [4];
   logic              deg_ff, deg_in;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign in_pop    = advance && in_valid;
   assign rsp_valid = rsp_valid_ff;

   // shift every magnitude left until the largest reaches bit 30
   for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
      localparam int K = 2 ** (NORM_STEPS - 1 - j);

      if (j == 0) begin : g_first
         assign nsrc[j]       = in_data;
         assign nsrc_valid[j] = in_valid;
      end else begin : g_next
         assign nsrc[j]       = norm_ff[j-1];
         assign nsrc_valid[j] = nvalid_ff[j-1];
      end

      always_comb begin
         norm_in[j] = nsrc[j];
         if (nsrc[j].mx[MAG_W-1 -: K] == '0) begin
            norm_in[j].mx = nsrc[j].mx << K;
            for (int i = 0; i < 4; i++) begin
               norm_in[j].mag[i] = nsrc[j].mag[i] << K;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            nvalid_ff[j] <= 1'b0;
         end else if (advance) begin
            nvalid_ff[j] <= nsrc_valid[j];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            norm_ff[j] <= norm_in[j];
         end
      end
   end

   // squares, then two levels of adds
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sq_in[i] = SQ_W'(norm_ff[NORM_STEPS-1].mag[i]) *
                    SQ_W'(norm_ff[NORM_STEPS-1].mag[i]);
      end
      sq_side_in.mag   = norm_ff[NORM_STEPS-1].mag;
      sq_side_in.neg   = norm_ff[NORM_STEPS-1].neg;
      sq_side_in.degen = norm_ff[NORM_STEPS-1].degen;
      pair_in[0] = PAIR_W'(sq_ff[0]) + PAIR_W'(sq_ff[1]);
      pair_in[1] = PAIR_W'(sq_ff[2]) + PAIR_W'(sq_ff[3]);
      sum_in     = SUM_W'(pair_ff[0]) + SUM_W'(pair_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff   <= 1'b0;
         pair_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else if (advance) begin
         sq_valid_ff   <= nvalid_ff[NORM_STEPS-1];
         pair_valid_ff <= sq_valid_ff;
         sum_valid_ff  <= pair_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ff        <= sq_in;
         sq_side_ff   <= sq_side_in;
         pair_ff      <= pair_in;
         pair_side_ff <= sq_side_ff;
         sum_ff       <= sum_in;
         sum_side_ff  <= pair_side_ff;
      end
   end

   rmq_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sum_valid_ff),
      .in_value  (sum_ff),
      .in_side   (sum_side_ff),
      .out_valid (root_valid),
      .out_root  (root),
      .out_side  (root_side)
   );

   // dividends with half the root added for rounding
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         drem_in[0][i] = (DIV_W'(root_side.mag[i]) << FRAC_BITS) + DIV_W'(root >> 1);
         dq_in[0][i]   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvalid_ff[0] <= 1'b0;
      end else if (advance) begin
         dvalid_ff[0] <= root_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         drem_ff[0] <= drem_in[0];
         dq_ff[0]   <= dq_in[0];
         dn_ff[0]   <= root;
         dneg_ff[0] <= root_side.neg;
         ddeg_ff[0] <= root_side.degen;
      end
   end

   // restoring division, one quotient bit per stage, four lanes
   for (genvar s = 0; s < Q_W; s++) begin : g_div
      localparam int K = FRAC_BITS - s;
      logic [DIV_W-1:0] den;
      logic [3:0]       ge;

      always_comb begin
         den = DIV_W'(dn_ff[s]) << K;
         for (int i = 0; i < 4; i++) begin
            ge[i]           = (drem_ff[s][i] >= den);
            drem_in[s+1][i] = ge[i] ? drem_ff[s][i] - den : drem_ff[s][i];
            dq_in[s+1][i]   = Q_W'({dq_ff[s][i], ge[i]});
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dvalid_ff[s+1] <= 1'b0;
         end else if (advance) begin
            dvalid_ff[s+1] <= dvalid_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            drem_ff[s+1] <= drem_in[s+1];
            dq_ff[s+1]   <= dq_in[s+1];
            dn_ff[s+1]   <= dn_ff[s];
            dneg_ff[s+1] <= dneg_ff[s];
            ddeg_ff[s+1] <= ddeg_ff[s];
         end
      end
   end

   // sign, saturation and identity fallback
   always_comb begin
      logic [31:0]        qx;
      logic signed [16:0] v;
      qx = '0;
      v  = '0;
      for (int i = 0; i < 4; i++) begin
         qx = 32'(dq_ff[Q_W][i]);
         if (!dneg_ff[Q_W][i]) begin
            v = (qx > 32'd32767) ? 17'sd32767 : 17'(qx);
         end else begin
            v = (qx > 32'd32768) ? -17'sd32768 : -$signed(17'(qx));
         end
         q_in[i] = ELEM_W'(v);
      end
      deg_in = ddeg_ff[Q_W];
      if (ddeg_ff[Q_W]) begin
         q_in[0] = ONE_SAT;
         q_in[1] = '0;
         q_in[2] = '0;
         q_in[3] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dvalid_ff[Q_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q_ff   <= q_in;
         deg_ff <= deg_in;
      end
   end

   assign rsp_quat_w     = q_ff[0];
   assign rsp_quat_x     = q_ff[1];
   assign rsp_quat_y     = q_ff[2];
   assign rsp_quat_z     = q_ff[3];
   assign rsp_degenerate = deg_ff;

endmodule
`default_nettype wire

// ----- bench/rotation_matrix_to_quaternion_tb.sv -----
// self-checking testbench for the rotation matrix to quaternion converter
`default_nettype none
module rotation_matrix_to_quaternion_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rmq_pkg::*;

   localparam int FRAC = 14;
   localparam int ONE = 1 << FRAC;
   localparam int LATENCY = FRAC + 45;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int N_RANDOM = 500;

   typedef struct packed {
      elem_type w, x, y, z;
      logic     degen;
   } quat_type;

   typedef struct {
      elem_type m [9];
      logic     has_exp;
      quat_type exp_q;
   } vec_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_stall = 0;
   logic req_stall, rsp_valid, rsp_degenerate;
   elem_type req_m00 = 0, req_m01 = 0, req_m02 = 0, req_m10 = 0, req_m11 = 0;
   elem_type req_m12 = 0, req_m20 = 0, req_m21 = 0, req_m22 = 0;
   elem_type rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;

   quat_type expected_quats [$];
   int errors = 0, accepted = 0, received = 0, degen_seen = 0, idle_cycles = 0;
   int send_idle = 0, recv_idle = 0;
   bit hold_off = 0, stim_done = 0;

   rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // integer square root, bit by bit
   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // shepperd branch selection, normalization and rounding
   function automatic quat_type convert_matrix(elem_type m [9]);
      longint t, rad, raw [4], v;
      longint unsigned mag [4], mx, sum, n, half, q;
      bit neg [4];
      quat_type r;
      t = ONE + m[0] + m[4] + m[8];
      rad = 1;
      if (t > 0) begin
         raw = '{t, m[7] - m[5], m[2] - m[6], m[3] - m[1]};
      end else if (m[0] >= m[4] && m[0] >= m[8]) begin
         rad = ONE + m[0] - m[4] - m[8];
         raw = '{m[7] - m[5], rad, m[1] + m[3], m[2] + m[6]};
      end else if (m[0] < m[4] && m[4] >= m[8]) begin
         rad = ONE - m[0] + m[4] - m[8];
         raw = '{m[2] - m[6], m[1] + m[3], rad, m[5] + m[7]};
      end else begin
         rad = ONE - m[0] - m[4] + m[8];
         raw = '{m[3] - m[1], m[2] + m[6], m[5] + m[7], rad};
      end
      mx = 0;
      for (int i = 0; i < 4; i++) begin
         neg[i] = raw[i] < 0;
         mag[i] = neg[i] ? -raw[i] : raw[i];
         if (mag[i] > mx) mx = mag[i];
      end
      if (rad <= 0 || mx == 0) begin
         r = '{w: ONE > 32767 ? 32767 : ONE, x: 0, y: 0, z: 0, degen: 1'b1};
         return r;
      end
      while (mx < (64'd1 << 30)) begin
         for (int i = 0; i < 4; i++) mag[i] <<= 1;
         mx <<= 1;
      end
      sum = 0;
      for (int i = 0; i < 4; i++) sum += mag[i] * mag[i];
      n = int_sqrt(sum);
      half = n >> 1;
      r.degen = 1'b0;
      for (int i = 0; i < 4; i++) begin
         q = ((mag[i] << FRAC) + half) / n;
         if (q > 65536) q = 65536;
         v = neg[i] ? -longint'(q) : longint'(q);
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         case (i)
            0: r.w = v[15:0];
            1: r.x = v[15:0];
            2: r.y = v[15:0];
            default: r.z = v[15:0];
         endcase
      end
      return r;
   endfunction

   // one line per mismatch
   task automatic report_mismatch(string what, int got, int want);
      errors++;
      $display("mismatch on %s: got %0d, expected %0d (result %0d)", what, got, want,
         received);
   endtask

   // drive one item and wait until it is taken
   task automatic send_matrix(vec_type v);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      {req_m00, req_m01, req_m02, req_m10, req_m11, req_m12, req_m20, req_m21, req_m22}
         <= {v.m[0], v.m[1], v.m[2], v.m[3], v.m[4], v.m[5], v.m[6], v.m[7], v.m[8]};
      expected_quats.push_back(v.has_exp ? v.exp_q : convert_matrix(v.m));
      @(posedge clock);
      while (req_stall) @(posedge clock);
      accepted++;
   endtask

   // random matrix: arbitrary noise, entries within one, or a dominant diagonal
   function automatic vec_type random_matrix();
      vec_type v;
      int k;
      k = $urandom_range(9);
      for (int i = 0; i < 9; i++) begin
         if (k < 3) v.m[i] = ELEM_W'($urandom);
         else if (k < 5) v.m[i] = ELEM_W'($urandom_range(2 * ONE) - ONE);
         else v.m[i] = (i % 4 == 0) ? ELEM_W'($urandom_range(2 * ONE) - ONE)
                                    : ELEM_W'($urandom_range(4096) - 2048);
      end
      if (k == 9) begin
         // force a non-trace branch with a random major axis
         v.m[0] = ELEM_W'(-ONE / 2 - $urandom_range(ONE / 2));
         v.m[4] = ELEM_W'(-ONE / 2 - $urandom_range(ONE / 2));
         v.m[8] = ELEM_W'(-ONE / 2 - $urandom_range(ONE / 2));
         v.m[3 * $urandom_range(2) + 0] = v.m[0];
      end
      v.has_exp = 0;
      return v;
   endfunction

   // directed table; the identity row carries a typed-in result
   localparam quat_type IDENT = '{w: ONE, x: 0, y: 0, z: 0, degen: 0};
   vec_type directed [18] = '{
      '{'{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1, IDENT},
      '{'{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}, 0, IDENT},
      '{'{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE}, 0, IDENT},
      '{'{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE}, 0, IDENT},
      '{'{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}, 0, IDENT},
      '{'{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}, 0, IDENT},
      '{'{-8192, 0, 0, 0, -8192, 0, 0, 0, 0}, 0, IDENT},
      '{'{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE + 1}, 0, IDENT},
      '{'{-6000, 0, 0, 0, -6000, 0, 0, 0, -6000}, 0, IDENT},
      '{'{-6000, 5, 7, 9, -6000, 11, 13, 15, -7000}, 0, IDENT},
      '{'{-7000, 5, 7, 9, -6000, 11, 13, 15, -6000}, 0, IDENT},
      '{'{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}, 0, IDENT},
      '{'{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, 0}, 0, IDENT},
      '{'{0, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0}, 0, IDENT},
      '{'{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE}, 0, IDENT},
      '{'{-1, -1, -1, -1, -1, -1, -1, -1, -1}, 0, IDENT},
      '{'{-ONE, 3, -3, 3, -ONE, 5, -5, 5, -ONE}, 0, IDENT},
      '{'{-ONE + 1, 0, 0, 0, -ONE + 1, 0, 0, 0, -ONE + 1}, 0, IDENT}
   };

   // stimulus
   initial begin
      vec_type v;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed[i]) send_matrix(directed[i]);
      // receiver holds off while the sender keeps going
      hold_off = 1;
      repeat (20) send_matrix(random_matrix());
      hold_off = 0;
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == 0) begin send_idle = 16; recv_idle = 59; end
         if (i == N_RANDOM / 3) begin send_idle = 59; recv_idle = 16; end
         if (i == 2 * N_RANDOM / 3) begin send_idle = 0; recv_idle = 0; end
         v = random_matrix();
         send_matrix(v);
      end
      req_valid <= 0;
      stim_done = 1;
   end

   // result-side stall, with a long hold-off counted here
   always @(posedge clock) begin
      if (hold_off) begin
         rsp_stall <= 1;
         if (!reset) begin
            repeat (300) @(posedge clock);
            rsp_stall <= 0;
            wait (!hold_off);
         end
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   // compare each result against the oldest expectation
   always @(posedge clock) begin
      quat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_quats.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            e = expected_quats.pop_front();
            if (rsp_quat_w !== e.w) report_mismatch("quat_w", rsp_quat_w, e.w);
            if (rsp_quat_x !== e.x) report_mismatch("quat_x", rsp_quat_x, e.x);
            if (rsp_quat_y !== e.y) report_mismatch("quat_y", rsp_quat_y, e.y);
            if (rsp_quat_z !== e.z) report_mismatch("quat_z", rsp_quat_z, e.z);
            if (rsp_degenerate !== e.degen)
               report_mismatch("degenerate", rsp_degenerate, e.degen);
         end
         received++;
         if (rsp_degenerate) degen_seen++;
      end
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", expected_quats.size());
         $display("rotation_matrix_to_quaternion_tb: done, errors");
         $finish;
      end
   end

   // end of run
   initial begin
      wait (stim_done);
      wait (expected_quats.size() == 0);
      repeat (2 * LATENCY) @(posedge clock);
      if (expected_quats.size() != 0) errors++;
      $display("%0d matrices sent, %0d quaternions checked, %0d degenerate", accepted,
         received, degen_seen);
      $display("covered trace and all three major-axis branches, extremes, long output stall");
      if (errors == 0)
         $display("rotation_matrix_to_quaternion_tb: done, clean");
      else
         $display("rotation_matrix_to_quaternion_tb: done, errors");
      $finish;
   end
endmodule
`default_nettype wire
